// ----- rtl/swcc_pkg.sv -----
// ----------------------------------------------------------------------------
// swcc_pkg
// Shared types and constants for the safety word CRC checker.
// ----------------------------------------------------------------------------
package swcc_pkg;

    localparam int CRC_W      = 8;
    localparam int WORD_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CRC_W-1:0] CRC_POLY_RESET = 8'h1D;
    localparam logic [CRC_W-1:0] CRC_SEED_RESET = 8'hFF;

    // Safety word flag positions (active high = healthy)
    localparam int SYS_OK_BIT   = 14;
    localparam int IF_OK_BIT    = 13;
    localparam int ANGLE_OK_BIT = 12;

    typedef enum logic [1:0] {
        ACT_COMMAND = 2'd0,
        ACT_DATA    = 2'd1,
        ACT_SAFETY  = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_SYS_ERR   = 3'd1,
        ST_IF_ERR    = 3'd2,
        ST_ANGLE_ERR = 3'd3,
        ST_CRC_ERR   = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CRC_POLY = 2'd0,
        REG_CRC_SEED = 2'd1
    } cfg_reg_t;

    // One input word held in the input register
    typedef struct packed {
        logic [1:0]        action;
        logic [WORD_W-1:0] word;
    } item_t;

    // One frame result
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   data_value;
        logic [CRC_W-1:0]    computed_crc;
        logic                reset_request;
    } result_t;

endpackage

// ----- rtl/swcc_ifs.sv -----
// ----------------------------------------------------------------------------
// swcc interfaces
// Valid/ready channels for input words, frame results and register writes.
// ----------------------------------------------------------------------------
interface swcc_word_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] word;

    modport source (output valid, output action, output word, input ready);
    modport sink   (input valid, input action, input word, output ready);
endinterface

interface swcc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] data_value;
    logic [7:0]  computed_crc;
    logic        reset_request;

    modport source (output valid, output status, output data_value,
                    output computed_crc, output reset_request, input ready);
    modport sink   (input valid, input status, input data_value,
                    input computed_crc, input reset_request, output ready);
endinterface

interface swcc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/swcc_crc_fold.sv -----
// ----------------------------------------------------------------------------
// swcc_crc_fold
// Folds a 16-bit word, high byte first, into a CRC-8 (MSB first).
// ----------------------------------------------------------------------------
module swcc_crc_fold (
    input  logic [swcc_pkg::CRC_W-1:0]  crc_in,
    input  logic [swcc_pkg::WORD_W-1:0] word,
    input  logic [swcc_pkg::CRC_W-1:0]  poly,
    output logic [swcc_pkg::CRC_W-1:0]  crc_out
);
    import swcc_pkg::*;

    // Sixteen unrolled shift/xor steps; low byte enters after the eighth
    always_comb
    begin
        logic [CRC_W-1:0] v;
        v = crc_in ^ word[WORD_W-1:CRC_W];
        for (int k = 0; k < WORD_W; k++)
        begin
            if (k == CRC_W)
            begin
                v = v ^ word[CRC_W-1:0];
            end
            if (v[CRC_W-1])
            begin
                v = {v[CRC_W-2:0], 1'b0} ^ poly;
            end
            else
            begin
                v = {v[CRC_W-2:0], 1'b0};
            end
        end
        crc_out = v;
    end

endmodule

// ----- rtl/swcc_frame_eval.sv -----
// ----------------------------------------------------------------------------
// swcc_frame_eval
// Frame state (CRC accumulator, last data word) and safety word evaluation.
// ----------------------------------------------------------------------------
module swcc_frame_eval (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  swcc_pkg::item_t            item,
    input  logic [swcc_pkg::CRC_W-1:0] poly,
    input  logic [swcc_pkg::CRC_W-1:0] seed,
    output swcc_pkg::result_t          result
);
    import swcc_pkg::*;

    logic [CRC_W-1:0]  acc_reg;
    logic [CRC_W-1:0]  acc_next;
    logic [WORD_W-1:0] held_reg;
    logic [WORD_W-1:0] held_next;
    logic [CRC_W-1:0]  fold_base;
    logic [CRC_W-1:0]  fold_crc;
    logic [CRC_W-1:0]  crc_inv;
    status_t           status;

    // Command words restart from the seed
    assign fold_base = (item.action == ACT_COMMAND) ? seed : acc_reg;

    swcc_crc_fold u_fold (
        .crc_in  (fold_base),
        .word    (item.word),
        .poly    (poly),
        .crc_out (fold_crc)
    );

    // State update
    always_comb
    begin
        acc_next  = acc_reg;
        held_next = held_reg;
        if (step)
        begin
            case (item.action)
                ACT_COMMAND:
                begin
                    acc_next  = fold_crc;
                    held_next = '0;
                end
                ACT_DATA:
                begin
                    acc_next  = fold_crc;
                    held_next = item.word;
                end
                default:
                begin
                    acc_next  = acc_reg;
                    held_next = held_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= CRC_SEED_RESET;
            held_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            held_reg <= held_next;
        end
    end

    // Status by priority
    assign crc_inv = ~acc_reg;

    always_comb
    begin
        if (!item.word[SYS_OK_BIT])
        begin
            status = ST_SYS_ERR;
        end
        else if (!item.word[IF_OK_BIT])
        begin
            status = ST_IF_ERR;
        end
        else if (!item.word[ANGLE_OK_BIT])
        begin
            status = ST_ANGLE_ERR;
        end
        else if (item.word[CRC_W-1:0] != crc_inv)
        begin
            status = ST_CRC_ERR;
        end
        else
        begin
            status = ST_OK;
        end
    end

    assign result.status        = status;
    assign result.data_value    = (status == ST_OK) ? held_reg : '0;
    assign result.computed_crc  = crc_inv;
    assign result.reset_request = (status == ST_CRC_ERR);

endmodule

// ----- rtl/safety_word_crc_checker_core.sv -----
// ----------------------------------------------------------------------------
// safety_word_crc_checker_core
// Word-by-word CRC-8 check of a sensor serial frame with safety status.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | role
//  --------+-----+------------------------------------------------+-----------------
//  frame   | in  | action, word                                   | link words
//  result  | out | status, data_value, computed_crc, reset_request| one per safety word
//  cfg     | in  | index, data                                    | register writes
//
//  One word per cycle unless a safety word waits on a stalled result. A result
//  is loaded from the input register into the result register. The CRC accumulator
//  is updated in the evaluation stage, so the sixteen-step fold sets the cycle time.
//  Reset loads polynomial 0x1D, seed 0xFF, accumulator 0xFF, data word 0.
//  A stalled result holds only safety words; command and data words keep
//  flowing until a safety word waits in the input register. cfg is always ready.
// ----------------------------------------------------------------------------
module safety_word_crc_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    swcc_word_if.sink   frame,
    swcc_result_if.source result,
    swcc_cfg_if.sink    cfg
);
    import swcc_pkg::*;

    logic [CRC_W-1:0] poly_reg;
    logic [CRC_W-1:0] seed_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    item_t            item_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_reg;
    result_t          eval_res;
    logic             out_free;
    logic             step;
    logic             out_load;

    // Register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= CRC_POLY_RESET;
            seed_reg <= CRC_SEED_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CRC_POLY: poly_reg <= cfg.data;
                REG_CRC_SEED: seed_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    // Stage handshake: only safety words need a free result slot
    assign out_free = !out_valid_reg || result.ready;
    assign step     = in_valid_reg && ((item_reg.action != ACT_SAFETY) || out_free);
    assign out_load = step && (item_reg.action == ACT_SAFETY);

    assign frame.ready    = !in_valid_reg || step;
    assign in_valid_next  = frame.valid || (in_valid_reg && !step);
    assign out_valid_next = out_load || (out_valid_reg && !result.ready);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (frame.ready)
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            item_reg.action <= frame.action;
            item_reg.word   <= frame.word;
        end
    end

    // Evaluation stage
    swcc_frame_eval u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .poly   (poly_reg),
        .seed   (seed_reg),
        .result (eval_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= eval_res;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_reg.status;
    assign result.data_value    = out_reg.data_value;
    assign result.computed_crc  = out_reg.computed_crc;
    assign result.reset_request = out_reg.reset_request;

endmodule
